### rtl/rrs_pkg.sv
package rrs_pkg;

    localparam int BUFFER_BYTES = 32;
    localparam int LEN_W = 6;
    localparam int AGE_W = 16;
    localparam int POS_W = 5;
    localparam int BYTE_W = 8;
    localparam int MAX_LOAD = 32;

    typedef enum logic [1:0] {
        KIND_HANDLE  = 2'd0,
        KIND_TRUNC   = 2'd1,
        KIND_DATA    = 2'd2,
        KIND_INVALID = 2'd3
    } t_kind;

    typedef enum logic {
        REQ_STORE = 1'b0,
        REQ_LOAD  = 1'b1
    } t_req;

    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } t_state;

endpackage

### rtl/rrs_if.sv
interface rrs_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  store_byte;
    logic        store_last;
    logic [4:0]  handle_pos;
    logic [5:0]  handle_length;
    logic [15:0] handle_age;

    modport source (output valid, req_type, store_byte, store_last, handle_pos,
                    handle_length, handle_age, input ready);
    modport sink (input valid, req_type, store_byte, store_last, handle_pos,
                  handle_length, handle_age, output ready);
endinterface

interface rrs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [4:0]  out_pos;
    logic [5:0]  out_length;
    logic [15:0] out_age;
    logic [7:0]  out_byte;
    logic        last;

    modport source (output valid, kind, out_pos, out_length, out_age, out_byte, last,
                    input ready);
    modport sink (input valid, kind, out_pos, out_length, out_age, out_byte, last,
                  output ready);
endinterface

### rtl/rrs_ram.sv
module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rrs_load_chk.sv
module rrs_load_chk (
    input  logic [rrs_pkg::POS_W-1:0]                 i_pos,
    input  logic [rrs_pkg::LEN_W-1:0]                 i_len,
    input  logic [rrs_pkg::AGE_W-1:0]                 i_age,
    input  logic [$clog2(rrs_pkg::BUFFER_BYTES)-1:0]  i_wp,
    input  logic [rrs_pkg::AGE_W-1:0]                 i_gen,
    output logic                                      o_ok
);
    import rrs_pkg::*;

    localparam int SUM_W = 7;
    localparam logic [SUM_W-1:0] BUF_N = SUM_W'(BUFFER_BYTES);
    localparam logic [SUM_W-1:0] MAX_N = SUM_W'(MAX_LOAD);

    logic [SUM_W-1:0] pos_x;
    logic [SUM_W-1:0] len_x;
    logic [SUM_W-1:0] wp_x;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] end_x;
    logic [AGE_W-1:0] age_diff;
    logic             shape_ok;
    logic             same_gen;
    logic             prev_gen;

    always_comb begin
        pos_x = SUM_W'(i_pos);
        len_x = SUM_W'(i_len);
        wp_x = SUM_W'(i_wp);
        sum = pos_x + len_x;
        // sum stays below twice the ring size when the shape is legal
        end_x = (sum >= BUF_N) ? sum - BUF_N : sum;
        age_diff = i_gen - i_age;
        shape_ok = (len_x != '0) && (len_x <= BUF_N) && (len_x <= MAX_N) && (pos_x < BUF_N);
        same_gen = (i_age == i_gen) && (end_x <= wp_x);
        prev_gen = (age_diff == AGE_W'(1)) && (pos_x >= wp_x);
        o_ok = shape_ok && (same_gen || prev_gen);
    end

endmodule

### rtl/ring_record_store_with_handles.sv
// Byte ring store with generation-tagged handles. A store item appends one byte
// at the write pointer; a record's final byte returns a handle (start, length,
// generation at start), kind 1 if the record outgrew the ring and was cut at
// BUFFER_BYTES bytes. A load item's handle is checked against the pointer and
// generation on acceptance; an intact record then streams through the registered
// RAM read one byte per cycle while the sink is ready, with no new item taken in
// the meantime; a stale or malformed handle returns a single invalid result.
// Bytes leave through an output register, so a store can be accepted while a
// handle still waits there provided the sink takes it in the same cycle.
module ring_record_store_with_handles (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rrs_in_if.sink       i_in,
    rrs_out_if.source    o_out
);
    import rrs_pkg::*;

    localparam int PTR_W = $clog2(BUFFER_BYTES);
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_BYTES);

    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [AGE_W-1:0]  r_gen, n_gen;
    logic [PTR_W-1:0]  r_start, n_start;
    logic [AGE_W-1:0]  r_rgen, n_rgen;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_open, n_open;
    logic              r_trunc, n_trunc;
    logic [PTR_W-1:0]  r_idx, n_idx;
    logic [LEN_W-1:0]  r_issue_left, n_issue_left;
    logic [LEN_W-1:0]  r_out_left, n_out_left;
    logic              r_pend, n_pend;

    logic              r_out_valid, n_out_valid;
    t_kind             r_kind, n_kind;
    logic [POS_W-1:0]  r_out_pos, n_out_pos;
    logic [LEN_W-1:0]  r_out_length, n_out_length;
    logic [AGE_W-1:0]  r_out_age, n_out_age;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_last, n_last;

    logic              out_free;
    logic              in_ready;
    logic              in_fire;
    logic              is_load;
    logic              load_ok;
    logic              move;
    logic              issue;

    logic              ram_we;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    logic [PTR_W-1:0]  st_start;
    logic [AGE_W-1:0]  st_gen;
    logic [CNT_W-1:0]  st_cnt;
    logic              st_trunc;

    rrs_load_chk u_chk (
        .i_pos (i_in.handle_pos),
        .i_len (i_in.handle_length),
        .i_age (i_in.handle_age),
        .i_wp  (r_wp),
        .i_gen (r_gen),
        .o_ok  (load_ok)
    );

    rrs_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_BYTES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_in.store_byte),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || o_out.ready;
    assign in_ready = (r_state == ST_IDLE) && out_free;
    assign in_fire = i_in.valid && in_ready;
    assign is_load = (i_in.req_type == REQ_LOAD);
    assign move = (r_state == ST_LOAD) && r_pend && out_free;
    assign issue = (r_state == ST_LOAD) && (r_issue_left != '0) && (!r_pend || out_free);
    assign ram_re = issue;
    assign ram_we = in_fire && !is_load && (st_cnt < CNT_FULL);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && is_load && load_ok) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (move && (r_out_left == LEN_W'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        // context of the open record, or a fresh one starting here
        st_start = r_open ? r_start : r_wp;
        st_gen = r_open ? r_rgen : r_gen;
        st_cnt = r_open ? r_cnt : '0;
        st_trunc = r_open && r_trunc;

        n_wp = r_wp;
        n_gen = r_gen;
        n_start = r_start;
        n_rgen = r_rgen;
        n_cnt = r_cnt;
        n_open = r_open;
        n_trunc = r_trunc;
        n_idx = r_idx;
        n_issue_left = r_issue_left;
        n_out_left = r_out_left;
        n_pend = r_pend;

        n_out_valid = r_out_valid && !o_out.ready;
        n_kind = r_kind;
        n_out_pos = r_out_pos;
        n_out_length = r_out_length;
        n_out_age = r_out_age;
        n_out_byte = r_out_byte;
        n_last = r_last;

        if (in_fire && !is_load) begin
            n_start = st_start;
            n_rgen = st_gen;
            n_cnt = st_cnt;
            n_trunc = st_trunc;
            if (st_cnt < CNT_FULL) begin
                n_cnt = st_cnt + CNT_W'(1);
                if (r_wp == PTR_LAST) begin
                    n_wp = '0;
                    n_gen = r_gen + AGE_W'(1);
                end else begin
                    n_wp = r_wp + PTR_W'(1);
                end
            end else begin
                n_trunc = 1'b1;
            end
            if (i_in.store_last) begin
                n_out_valid = 1'b1;
                n_kind = n_trunc ? KIND_TRUNC : KIND_HANDLE;
                n_out_pos = POS_W'(st_start);
                n_out_length = LEN_W'(n_cnt);
                n_out_age = st_gen;
                n_out_byte = '0;
                n_last = 1'b1;
                n_open = 1'b0;
                n_trunc = 1'b0;
                n_cnt = '0;
            end else begin
                n_open = 1'b1;
            end
        end

        if (in_fire && is_load) begin
            if (load_ok) begin
                n_idx = PTR_W'(i_in.handle_pos);
                n_issue_left = i_in.handle_length;
                n_out_left = i_in.handle_length;
                n_pend = 1'b0;
            end else begin
                n_out_valid = 1'b1;
                n_kind = KIND_INVALID;
                n_out_pos = '0;
                n_out_length = '0;
                n_out_age = '0;
                n_out_byte = '0;
                n_last = 1'b1;
            end
        end

        // stream: hand the read byte to the output, refill behind it
        if (move) begin
            n_out_valid = 1'b1;
            n_kind = KIND_DATA;
            n_out_pos = '0;
            n_out_length = '0;
            n_out_age = '0;
            n_out_byte = ram_rdata;
            n_last = (r_out_left == LEN_W'(1));
            n_out_left = r_out_left - LEN_W'(1);
            n_pend = 1'b0;
        end
        if (issue) begin
            n_pend = 1'b1;
            n_issue_left = r_issue_left - LEN_W'(1);
            n_idx = (r_idx == PTR_LAST) ? '0 : r_idx + PTR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wp <= '0;
            r_gen <= '0;
            r_start <= '0;
            r_rgen <= '0;
            r_cnt <= '0;
            r_open <= 1'b0;
            r_trunc <= 1'b0;
            r_issue_left <= '0;
            r_out_left <= '0;
            r_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp <= n_wp;
            r_gen <= n_gen;
            r_start <= n_start;
            r_rgen <= n_rgen;
            r_cnt <= n_cnt;
            r_open <= n_open;
            r_trunc <= n_trunc;
            r_issue_left <= n_issue_left;
            r_out_left <= n_out_left;
            r_pend <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_kind <= n_kind;
        r_out_pos <= n_out_pos;
        r_out_length <= n_out_length;
        r_out_age <= n_out_age;
        r_out_byte <= n_out_byte;
        r_last <= n_last;
    end

    assign i_in.ready = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.kind = r_kind;
    assign o_out.out_pos = r_out_pos;
    assign o_out.out_length = r_out_length;
    assign o_out.out_age = r_out_age;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last = r_last;

endmodule

### tb/tb_ring_record_store_with_handles.sv
module tb_ring_record_store_with_handles;
    import rrs_pkg::*;

    localparam int RING_BYTES = BUFFER_BYTES;
    localparam int MAX_SHOWN = 20;
    localparam int RECENT_KEPT = 8;

    typedef struct {
        t_req              req;
        logic [BYTE_W-1:0] sbyte;
        logic              slast;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic [AGE_W-1:0]  age;
    } ring_req_t;

    typedef struct {
        t_kind             kind;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic [AGE_W-1:0]  age;
        logic [BYTE_W-1:0] data;
        logic              last;
    } ring_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    rrs_in_if  in_if ();
    rrs_out_if out_if ();

    ring_record_store_with_handles dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // shadow of the ring and its pointers, advanced on each accepted transfer
    logic [BYTE_W-1:0] ring_mem [RING_BYTES];
    bit                ring_written [RING_BYTES];
    int                wr_ptr = 0;
    logic [AGE_W-1:0]  cur_gen = '0;
    int                open_start = 0;
    logic [AGE_W-1:0]  open_gen = '0;
    int                open_count = 0;
    bit                open_active = 1'b0;
    bit                open_trunc = 1'b0;

    ring_result_t expected_results [$];
    ring_result_t recent_handles [$];

    int  errors = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  handles_seen = 0;
    int  truncated_seen = 0;
    int  intact_loads = 0;
    int  invalid_loads = 0;
    int  hold_cycles = 0;
    bit  quiet = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    endtask

    function automatic void expect_result(input ring_result_t res);
        expected_results = {expected_results, res};
    endfunction

    function automatic bit load_intact(input ring_req_t r);
        int tail;
        logic [AGE_W-1:0] age_gap;
        if (r.len < 1 || r.len > RING_BYTES || r.len > MAX_LOAD)
            return 1'b0;
        tail = (int'(r.pos) + int'(r.len)) % RING_BYTES;
        age_gap = cur_gen - r.age;
        return (r.age == cur_gen && tail <= wr_ptr) || (age_gap == 16'd1 && int'(r.pos) >= wr_ptr);
    endfunction

    function automatic bit touches_unwritten(input ring_req_t r);
        for (int i = 0; i < int'(r.len); i++) begin
            if (!ring_written[(int'(r.pos) + i) % RING_BYTES])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic predict_results(input ring_req_t r);
        ring_result_t res;
        int idx;
        if (r.req == REQ_STORE) begin
            if (!open_active) begin
                open_active = 1'b1;
                open_trunc = 1'b0;
                open_start = wr_ptr;
                open_gen = cur_gen;
                open_count = 0;
            end
            if (open_count < RING_BYTES) begin
                ring_mem[wr_ptr] = r.sbyte;
                ring_written[wr_ptr] = 1'b1;
                wr_ptr++;
                if (wr_ptr >= RING_BYTES) begin
                    wr_ptr = 0;
                    cur_gen = cur_gen + 16'd1;
                end
                open_count++;
            end else begin
                // drop bytes beyond the ring size
                open_trunc = 1'b1;
            end
            if (r.slast) begin
                res = '{kind: open_trunc ? KIND_TRUNC : KIND_HANDLE,
                        pos: open_start[POS_W-1:0], len: open_count[LEN_W-1:0],
                        age: open_gen, data: '0, last: 1'b1};
                expect_result(res);
                recent_handles = {recent_handles, res};
                if (recent_handles.size() > RECENT_KEPT)
                    void'(recent_handles.pop_front());
                handles_seen++;
                if (open_trunc)
                    truncated_seen++;
                open_active = 1'b0;
                open_trunc = 1'b0;
                open_count = 0;
            end
        end else if (!load_intact(r)) begin
            expect_result('{kind: KIND_INVALID, pos: '0, len: '0, age: '0,
                            data: '0, last: 1'b1});
            invalid_loads++;
        end else begin
            idx = int'(r.pos);
            for (int i = 0; i < int'(r.len); i++) begin
                expect_result('{kind: KIND_DATA, pos: '0, len: '0, age: '0,
                                data: ring_mem[idx],
                                last: (i == int'(r.len) - 1)});
                idx = (idx + 1) % RING_BYTES;
            end
            intact_loads++;
        end
    endtask

    function automatic ring_req_t store_req(input logic [BYTE_W-1:0] b, input logic fin);
        ring_req_t r;
        r.req = REQ_STORE;
        r.sbyte = b;
        r.slast = fin;
        r.pos = POS_W'($urandom);
        r.len = LEN_W'($urandom);
        r.age = AGE_W'($urandom);
        return r;
    endfunction

    function automatic ring_req_t load_req(input logic [POS_W-1:0] p,
                                           input logic [LEN_W-1:0] n,
                                           input logic [AGE_W-1:0] a);
        ring_req_t r;
        r.req = REQ_LOAD;
        r.sbyte = BYTE_W'($urandom);
        r.slast = 1'($urandom);
        r.pos = p;
        r.len = n;
        r.age = a;
        return r;
    endfunction

    task automatic send_item(input ring_req_t r);
        ring_req_t q;
        q = r;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        // retarget an intact load that would read never-written ring bytes
        if (q.req == REQ_LOAD && load_intact(q) && touches_unwritten(q))
            q.age = cur_gen + 16'd2;
        in_if.req_type = q.req;
        in_if.store_byte = q.sbyte;
        in_if.store_last = q.slast;
        in_if.handle_pos = q.pos;
        in_if.handle_length = q.len;
        in_if.handle_age = q.age;
        in_if.valid = 1'b1;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predict_results(q);
        items_sent++;
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_record(input int len);
        for (int i = 0; i < len; i++)
            send_item(store_req(BYTE_W'($urandom), i == len - 1));
    endtask

    function automatic int pick_record_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 6);
        if (r < 95)
            return $urandom_range(7, 31);
        return $urandom_range(32, 40);
    endfunction

    task automatic random_traffic(input int count);
        int stop_at;
        int pick;
        ring_result_t h;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                send_record(pick_record_length());
            end else if (pick < 85 && recent_handles.size() > 0) begin
                h = recent_handles[$urandom_range(0, recent_handles.size() - 1)];
                case ($urandom_range(0, 5))
                    0: h.pos = POS_W'($urandom);
                    1: h.len = LEN_W'($urandom);
                    2: h.age = h.age + 16'd1;
                    3: h.age = h.age - 16'd1;
                    default: ;
                endcase
                send_item(load_req(h.pos, h.len, h.age));
            end else begin
                send_item(load_req(POS_W'($urandom), LEN_W'($urandom), AGE_W'($urandom)));
            end
        end
    endtask

    task automatic test_directed();
        send_item(store_req(8'h00, 1'b1));
        send_item(store_req(8'hFF, 1'b0));
        send_item(store_req(8'hA5, 1'b1));
        send_item(load_req(5'd0, 6'd1, 16'h0000));
        send_item(load_req(5'd1, 6'd2, 16'h0000));
        send_item(load_req(5'd0, 6'd0, 16'h0000));
        send_item(load_req(5'd0, 6'd33, 16'h0000));
        send_item(load_req(5'd2, 6'd63, 16'hFFFF));
        send_item(load_req(5'd1, 6'd2, 16'h0001));
        // record ending right at the write pointer, then one byte past it
        send_item(load_req(5'd0, 6'd3, 16'h0000));
        send_item(load_req(5'd3, 6'd1, 16'h0000));
        wait_results_drained();
    endtask

    task automatic test_long_record();
        send_record(RING_BYTES + 1);
        send_item(load_req(5'd3, 6'd32, 16'h0000));
        send_item(load_req(5'd0, 6'd1, 16'h0000));
        send_item(load_req(5'd4, 6'd32, 16'h0000));
        send_record(2);
        send_item(load_req(5'd3, 6'd2, 16'h0001));
        send_item(load_req(5'd31, 6'd2, 16'h0000));
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        // sink holds off while stores and loads keep coming
        @(posedge i_clk);
        hold_cycles = 300;
        random_traffic(40);
        wait_results_drained();
    endtask

    task automatic test_random();
        random_traffic(180);
        wait_results_drained();
        random_traffic(180);
        wait_results_drained();
    endtask

    task automatic test_unthrottled();
        quiet = 1'b1;
        random_traffic(60);
        wait_results_drained();
    endtask

    always @(posedge i_clk) begin : check_result
        ring_result_t want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected, kind", out_if.kind, 0);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (out_if.kind !== want.kind)
                    report_mismatch("kind", out_if.kind, want.kind);
                if (out_if.out_pos !== want.pos)
                    report_mismatch("out_pos", out_if.out_pos, want.pos);
                if (out_if.out_length !== want.len)
                    report_mismatch("out_length", out_if.out_length, want.len);
                if (out_if.out_age !== want.age)
                    report_mismatch("out_age", out_if.out_age, want.age);
                if (out_if.out_byte !== want.data)
                    report_mismatch("out_byte", out_if.out_byte, want.data);
                if (out_if.last !== want.last)
                    report_mismatch("last", out_if.last, want.last);
            end
        end
    end

    initial begin : sink_side
        int stall_left;
        stall_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                out_if.ready = 1'b0;
                hold_cycles--;
            end else if (quiet) begin
                out_if.ready = 1'b1;
            end else if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                out_if.ready = 1'b0;
                stall_left = $urandom_range(0, 10);
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    initial begin : run
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.req_type = REQ_STORE;
        in_if.store_byte = '0;
        in_if.store_last = 1'b0;
        in_if.handle_pos = '0;
        in_if.handle_length = '0;
        in_if.handle_age = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_long_record();
        test_backpressure();
        test_random();
        test_unthrottled();

        repeat (40) @(posedge i_clk);
        $display("Run covered %0d transfers in, %0d results checked, %0d handles (%0d cut)",
                 items_sent, results_checked, handles_seen, truncated_seen);
        $display("Loads: %0d intact, %0d rejected as stale or malformed",
                 intact_loads, invalid_loads);
        if (errors == 0) begin
            $display("tb_ring_record_store_with_handles passed");
        end else begin
            $display("tb_ring_record_store_with_handles failed");
        end
        $finish;
    end

    initial begin : watchdog
        #10000000;
        $display("tb_ring_record_store_with_handles failed");
        $finish;
    end

endmodule

### ring_record_store_with_handles.f
rtl/rrs_pkg.sv
rtl/rrs_if.sv
rtl/rrs_ram.sv
rtl/rrs_load_chk.sv
rtl/ring_record_store_with_handles.sv
tb/tb_ring_record_store_with_handles.sv
